// ===== sv/tea_pkg.sv =====
package tea_pkg;

    // slot banks
    localparam int TIMER_SLOTS = 8;
    localparam int ANIM_SLOTS  = 8;
    localparam int SLOT_W      = 3;

    localparam logic [15:0] FULL_SCALE = 16'd65535;
    localparam logic [15:0] HALF_SCALE = 16'd32768;

    // input opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ARM   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_FIRED  = 3'd0;
    localparam logic [2:0] KIND_VALUE  = 3'd1;
    localparam logic [2:0] KIND_DONE   = 3'd2;
    localparam logic [2:0] KIND_OK     = 3'd3;
    localparam logic [2:0] KIND_REJECT = 3'd4;

    // easing paths
    localparam logic [1:0] PATH_LINEAR = 2'd0;
    localparam logic [1:0] PATH_IN     = 2'd1;
    localparam logic [1:0] PATH_OUT    = 2'd2;
    localparam logic [1:0] PATH_INOUT  = 2'd3;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_ARM,
        CMD_START,
        CMD_REJECT
    } t_cmd;

    // one classified command word between front and back
    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       amount;
        logic              repeat_flag;
        logic [1:0]        path;
        logic [31:0]       from_value;
        logic [31:0]       to_value;
    } t_cmd_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TIMER,
        S_ANIM,
        S_DIV,
        S_EASE_MUL,
        S_EASE_DIV,
        S_VAL_MUL,
        S_FOLD_INIT,
        S_FOLD,
        S_VAL_OUT,
        S_DONE_OUT,
        S_FINAL
    } t_bstate;

    // floor(x / 65535) for x below 65535 * 2^18, by folding the high half twice
    function automatic logic [17:0] div65535(input logic [33:0] x);
        logic [17:0] q0;
        logic [18:0] r;
        logic [2:0]  q1;
        logic [16:0] r2;
        logic        c;
        q0 = x[33:16];
        r  = {3'b0, x[15:0]} + {1'b0, q0};
        q1 = r[18:16];
        r2 = {1'b0, r[15:0]} + {14'b0, q1};
        c  = (r2 >= 17'd65535);
        return q0 + {15'b0, q1} + {17'b0, c};
    endfunction

endpackage

// ===== sv/tea_front.sv =====
module tea_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     i_busy_q,
    input  logic [1:0]               i_opcode,
    input  logic [2:0]               i_slot,
    input  logic [31:0]              i_amount_ms,
    input  logic                     i_repeat_flag,
    input  logic [1:0]               i_ease_path,
    input  logic [31:0]              i_from_value,
    input  logic [31:0]              i_to_value,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_wdata,
    output logic                     o_push,
    output tea_pkg::t_cmd_word       o_word
);
    import tea_pkg::*;

    logic r_enable;
    logic timer_oor;
    logic anim_oor;

    // engine enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_enable <= i_cfg_wdata;
        end
    end

    assign timer_oor = ({1'b0, i_slot} >= 4'(TIMER_SLOTS));
    assign anim_oor  = ({1'b0, i_slot} >= 4'(ANIM_SLOTS));
    assign o_push    = start && !i_busy_q;

    // classify the incoming word
    always_comb begin
        o_word.slot        = i_slot;
        o_word.amount      = i_amount_ms;
        o_word.repeat_flag = i_repeat_flag;
        o_word.path        = i_ease_path;
        o_word.from_value  = i_from_value;
        o_word.to_value    = i_to_value;
        o_word.cmd         = CMD_REJECT;
        case (i_opcode)
            OP_TICK: begin
                if (r_enable) begin
                    o_word.cmd = CMD_TICK;
                end else begin
                    o_word.slot = '0;
                end
            end
            OP_ARM: begin
                if (!timer_oor) o_word.cmd = CMD_ARM;
            end
            OP_START: begin
                if (!anim_oor) o_word.cmd = CMD_START;
            end
            default: o_word.cmd = CMD_REJECT;
        endcase
    end

endmodule

// ===== sv/tea_queue.sv =====
module tea_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tea_pkg::t_cmd_word i_word,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output tea_pkg::t_cmd_word o_word
);
    import tea_pkg::*;

    t_cmd_word  r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_word  = r_mem[r_rptr];

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/tea_back.sv =====
module tea_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  tea_pkg::t_cmd_word i_word,
    output logic               o_pop,
    output logic               o_result_valid,
    output logic [2:0]         o_kind,
    output logic [2:0]         o_index,
    output logic [31:0]        o_value,
    output logic [31:0]        o_now_ms,
    output logic               o_last
);
    import tea_pkg::*;

    // slot state
    logic        r_t_act [TIMER_SLOTS];
    logic        r_t_rep [TIMER_SLOTS];
    logic [31:0] r_t_per [TIMER_SLOTS];
    logic [31:0] r_t_el  [TIMER_SLOTS];
    logic        r_a_act [ANIM_SLOTS];
    logic [1:0]  r_a_path[ANIM_SLOTS];
    logic [31:0] r_a_dur [ANIM_SLOTS];
    logic [31:0] r_a_el  [ANIM_SLOTS];
    logic [31:0] r_a_from[ANIM_SLOTS];
    logic [31:0] r_a_to  [ANIM_SLOTS];

    t_bstate            r_state, n_state;
    logic [31:0]        r_time, n_time;
    logic [31:0]        r_amt, n_amt;
    logic [SLOT_W-1:0]  r_i, n_i;
    logic [31:0]        r_el, n_el;
    logic [31:0]        r_dur, n_dur;
    logic [15:0]        r_num, n_num;
    logic [32:0]        r_rem, n_rem;
    logic [15:0]        r_quo, n_quo;
    logic [4:0]         r_cnt, n_cnt;
    logic [31:0]        r_sq, n_sq;
    logic [15:0]        r_eased, n_eased;
    logic signed [49:0] r_prod, n_prod;
    logic               r_neg, n_neg;
    logic [47:0]        r_x, n_x;
    logic [32:0]        r_q, n_q;

    logic               r_ov, n_ov;
    logic [2:0]         r_ok, n_ok;
    logic [2:0]         r_oi, n_oi;
    logic [31:0]        r_oval, n_oval;
    logic               r_olast, n_olast;

    // array write controls
    logic        t_load, t_upd, t_act_nx;
    logic [31:0] t_el_nx;
    logic        a_load, a_upd, a_act_nx;
    logic [31:0] a_el_nx;

    // per-step combinational helpers
    logic [32:0] t_sum;
    logic [31:0] t_sat;
    logic [32:0] a_sum;
    logic [31:0] a_new;
    logic [47:0] a_num;
    logic [32:0] d_rem2;
    logic [15:0] e_t, e_inv, e_op;
    logic        e_low;
    logic [17:0] e_q;
    logic [15:0] e_qs;
    logic signed [32:0] v_delta;
    logic [32:0] v_sum;
    logic [32:0] v_term;
    logic        last_anim;

    assign o_pop          = (r_state == S_IDLE) && !i_empty;
    assign o_result_valid = r_ov;
    assign o_kind         = r_ok;
    assign o_index        = r_oi;
    assign o_value        = r_oval;
    assign o_now_ms       = r_time;
    assign o_last         = r_olast;

    assign last_anim = (r_i == SLOT_W'(ANIM_SLOTS - 1));

    // timer step: saturating elapsed
    assign t_sum = {1'b0, r_t_el[r_i]} + {1'b0, r_amt};
    assign t_sat = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];

    // animation step: clamp at duration, progress numerator = e * 65535
    assign a_sum = {1'b0, r_a_el[r_i]} + {1'b0, r_amt};
    assign a_new = (a_sum >= {1'b0, r_a_dur[r_i]}) ? r_a_dur[r_i] : a_sum[31:0];
    assign a_num = {a_new, 16'b0} - {16'b0, a_new};

    assign d_rem2 = {r_rem[31:0], r_num[15]};

    // easing operands
    assign e_t   = r_quo;
    assign e_inv = FULL_SCALE - e_t;
    assign e_low = (e_t < HALF_SCALE);
    always_comb begin
        case (r_a_path[r_i])
            PATH_IN:    e_op = e_t;
            PATH_OUT:   e_op = e_inv;
            PATH_INOUT: e_op = e_low ? e_t : e_inv;
            default:    e_op = e_t;
        endcase
    end
    assign e_q  = div65535((r_a_path[r_i] == PATH_INOUT) ? {1'b0, r_sq, 1'b0}
                                                         : {2'b0, r_sq});
    assign e_qs = e_q[15:0];

    assign v_delta = $signed({r_a_to[r_i][31], r_a_to[r_i]})
                   - $signed({r_a_from[r_i][31], r_a_from[r_i]});
    assign v_term  = r_neg ? (33'd0 - r_q) : r_q;
    assign v_sum   = {r_a_from[r_i][31], r_a_from[r_i]} + v_term;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_time  = r_time;
        n_amt   = r_amt;
        n_i     = r_i;
        n_el    = r_el;
        n_dur   = r_dur;
        n_num   = r_num;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_sq    = r_sq;
        n_eased = r_eased;
        n_prod  = r_prod;
        n_neg   = r_neg;
        n_x     = r_x;
        n_q     = r_q;
        n_ov    = 1'b0;
        n_ok    = r_ok;
        n_oi    = r_oi;
        n_oval  = r_oval;
        n_olast = 1'b0;
        t_load = 1'b0; t_upd = 1'b0; t_act_nx = 1'b0; t_el_nx = '0;
        a_load = 1'b0; a_upd = 1'b0; a_act_nx = 1'b0; a_el_nx = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    case (i_word.cmd)
                        CMD_TICK: begin
                            n_time  = r_time + i_word.amount;
                            n_amt   = i_word.amount;
                            n_i     = '0;
                            n_state = S_TIMER;
                        end
                        CMD_ARM: begin
                            t_load = 1'b1;
                            n_ov = 1'b1; n_ok = KIND_OK; n_oi = i_word.slot;
                            n_oval = '0; n_olast = 1'b1;
                        end
                        CMD_START: begin
                            a_load = 1'b1;
                            n_ov = 1'b1; n_ok = KIND_OK; n_oi = i_word.slot;
                            n_oval = '0; n_olast = 1'b1;
                        end
                        default: begin
                            n_ov = 1'b1; n_ok = KIND_REJECT; n_oi = i_word.slot;
                            n_oval = '0; n_olast = 1'b1;
                        end
                    endcase
                end
            end
            S_TIMER: begin
                if (r_t_act[r_i] && (t_sat >= r_t_per[r_i])) begin
                    t_upd = 1'b1;
                    if (r_t_rep[r_i]) begin
                        t_act_nx = 1'b1;
                        t_el_nx  = t_sat - r_t_per[r_i];
                    end else begin
                        t_act_nx = 1'b0;
                        t_el_nx  = '0;
                    end
                    n_ov = 1'b1; n_ok = KIND_FIRED; n_oi = r_i; n_oval = '0;
                end else if (r_t_act[r_i]) begin
                    t_upd = 1'b1; t_act_nx = 1'b1; t_el_nx = t_sat;
                end
                if (r_i == SLOT_W'(TIMER_SLOTS - 1)) begin
                    n_i = '0;
                    n_state = S_ANIM;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_ANIM: begin
                if (r_a_act[r_i]) begin
                    a_upd = 1'b1; a_act_nx = 1'b1; a_el_nx = a_new;
                    n_el  = a_new;
                    n_dur = r_a_dur[r_i];
                    if (r_a_dur[r_i] == 32'd0) begin
                        n_quo   = FULL_SCALE;
                        n_state = S_EASE_MUL;
                    end else begin
                        n_rem   = {1'b0, a_num[47:16]};
                        n_num   = a_num[15:0];
                        n_quo   = '0;
                        n_cnt   = 5'd16;
                        n_state = S_DIV;
                    end
                end else if (last_anim) begin
                    n_state = S_FINAL;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (d_rem2 >= {1'b0, r_dur}) begin
                    n_rem = d_rem2 - {1'b0, r_dur};
                    n_quo = {r_quo[14:0], 1'b1};
                end else begin
                    n_rem = d_rem2;
                    n_quo = {r_quo[14:0], 1'b0};
                end
                n_num = {r_num[14:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) n_state = S_EASE_MUL;
            end
            S_EASE_MUL: begin
                n_sq = e_op * e_op;
                if (r_a_path[r_i] == PATH_LINEAR) begin
                    n_eased = e_t;
                    n_state = S_VAL_MUL;
                end else begin
                    n_state = S_EASE_DIV;
                end
            end
            S_EASE_DIV: begin
                case (r_a_path[r_i])
                    PATH_IN:    n_eased = e_qs;
                    PATH_OUT:   n_eased = FULL_SCALE - e_qs;
                    PATH_INOUT: n_eased = e_low ? e_qs : FULL_SCALE - e_qs;
                    default:    n_eased = e_t;
                endcase
                n_state = S_VAL_MUL;
            end
            S_VAL_MUL: begin
                n_prod  = 50'(v_delta * $signed({1'b0, r_eased}));
                n_state = S_FOLD_INIT;
            end
            S_FOLD_INIT: begin
                n_neg   = r_prod[49];
                n_x     = r_prod[49] ? 48'(50'd0 - r_prod) : r_prod[47:0];
                n_q     = '0;
                n_state = S_FOLD;
            end
            S_FOLD: begin
                // x/65535 by folding the high part into the low part
                if (r_x[47:16] != 32'd0) begin
                    n_q = r_q + {1'b0, r_x[47:16]};
                    n_x = {32'b0, r_x[15:0]} + {16'b0, r_x[47:16]};
                end else begin
                    if (r_x[15:0] == FULL_SCALE) n_q = r_q + 33'd1;
                    n_state = S_VAL_OUT;
                end
            end
            S_VAL_OUT: begin
                n_ov = 1'b1; n_ok = KIND_VALUE; n_oi = r_i; n_oval = v_sum[31:0];
                if (r_el >= r_dur) begin
                    n_state = S_DONE_OUT;
                end else if (last_anim) begin
                    n_state = S_FINAL;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_ANIM;
                end
            end
            S_DONE_OUT: begin
                a_upd = 1'b1; a_act_nx = 1'b0; a_el_nx = '0;
                n_ov = 1'b1; n_ok = KIND_DONE; n_oi = r_i; n_oval = '0;
                if (last_anim) begin
                    n_state = S_FINAL;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_ANIM;
                end
            end
            S_FINAL: begin
                n_ov = 1'b1; n_ok = KIND_OK; n_oi = '0; n_oval = '0; n_olast = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_time  <= '0;
            r_ov    <= 1'b0;
            r_olast <= 1'b0;
        end else begin
            r_state <= n_state;
            r_time  <= n_time;
            r_ov    <= n_ov;
            r_olast <= n_olast;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_amt   <= n_amt;
        r_i     <= n_i;
        r_el    <= n_el;
        r_dur   <= n_dur;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_sq    <= n_sq;
        r_eased <= n_eased;
        r_prod  <= n_prod;
        r_neg   <= n_neg;
        r_x     <= n_x;
        r_q     <= n_q;
        r_ok    <= n_ok;
        r_oi    <= n_oi;
        r_oval  <= n_oval;
    end

    // timer bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TIMER_SLOTS; k++) r_t_act[k] <= 1'b0;
        end else if (t_load) begin
            r_t_act[i_word.slot] <= 1'b1;
            r_t_rep[i_word.slot] <= i_word.repeat_flag;
            r_t_per[i_word.slot] <= i_word.amount;
            r_t_el[i_word.slot]  <= '0;
        end else if (t_upd) begin
            r_t_act[r_i] <= t_act_nx;
            r_t_el[r_i]  <= t_el_nx;
        end
    end

    // animation bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ANIM_SLOTS; k++) r_a_act[k] <= 1'b0;
        end else if (a_load) begin
            r_a_act[i_word.slot]  <= 1'b1;
            r_a_path[i_word.slot] <= i_word.path;
            r_a_dur[i_word.slot]  <= i_word.amount;
            r_a_el[i_word.slot]   <= '0;
            r_a_from[i_word.slot] <= i_word.from_value;
            r_a_to[i_word.slot]   <= i_word.to_value;
        end else if (a_upd) begin
            r_a_act[r_i] <= a_act_nx;
            r_a_el[r_i]  <= a_el_nx;
        end
    end

endmodule

// ===== sv/timer_and_easing_animation_engine.sv =====
// Timer bank and eased tween engine.
// Command channel: a word is taken on a rising edge with start high and busy
// low. Opcode 0 ticks the time base (rejected while the engine is disabled),
// 1 arms a timer slot, 2 starts an animation slot, 3 is rejected. Words go
// through a two-entry queue; busy is high while it is full.
// Results: at most one word per cycle on o_kind/o_index/o_value/o_now_ms
// and o_last, marked by o_result_valid for exactly one cycle; the receiver
// must take it. Each command's run ends with a word whose o_last is 1.
// Sequencing: arm, start and rejected words are answered from the result
// registers once they leave the queue. A tick leaves the queue, walks the
// timer slots, then the animation slots, stepping over idle ones; each
// active animation runs the bit-serial progress divider (skipped for a zero
// duration), the easing and value steps, its value word and, once finished,
// a done word. A closing word ends the run; the next word is popped after it.
// Config: o_cfg_ready is always high; i_cfg_wdata sets the engine enable.
// Reset clears the queue, every slot's active bit, the time base and enable.
module timer_and_easing_animation_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_slot,
    input  logic [31:0] i_amount_ms,
    input  logic        i_repeat_flag,
    input  logic [1:0]  i_ease_path,
    input  logic [31:0] i_from_value,
    input  logic [31:0] i_to_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_wdata,
    output logic        o_result_valid,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_index,
    output logic [31:0] o_value,
    output logic [31:0] o_now_ms,
    output logic        o_last
);
    import tea_pkg::*;

    logic      push, pop, full, empty;
    t_cmd_word f_word, q_word;

    assign busy        = full;
    assign o_cfg_ready = 1'b1;

    tea_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_busy_q     (full),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_amount_ms  (i_amount_ms),
        .i_repeat_flag(i_repeat_flag),
        .i_ease_path  (i_ease_path),
        .i_from_value (i_from_value),
        .i_to_value   (i_to_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push       (push),
        .o_word       (f_word)
    );

    tea_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_word (f_word),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_word (q_word)
    );

    tea_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_word        (q_word),
        .o_pop         (pop),
        .o_result_valid(o_result_valid),
        .o_kind        (o_kind),
        .o_index       (o_index),
        .o_value       (o_value),
        .o_now_ms      (o_now_ms),
        .o_last        (o_last)
    );

endmodule
